### sv/bond_pair_detector_defines.svh
// ---------------------------------------------------------------------------
// bond_pair_detector_defines.svh
// Assertion macros shared by the bond pair detector modules.
// ---------------------------------------------------------------------------
`ifndef BOND_PAIR_DETECTOR_DEFINES_SVH
`define BOND_PAIR_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define BPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define BPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bpd_pkg.sv
// ---------------------------------------------------------------------------
// bpd_pkg
// Shared widths, register indexes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package bpd_pkg;

  localparam int RAD_W   = 12;            // covalent radius, Q4.8
  localparam int TOL_W   = 12;            // bond tolerance, Q4.8
  localparam int IDX_W   = 6;             // output index width
  localparam int REACH_W = 14;            // radius + radius + tolerance
  localparam int SQ_W    = 2 * REACH_W;   // square of a clamped distance
  localparam int SUM_W   = SQ_W + 2;      // sum of three squares

  // register index, taken from paddr[2]
  localparam logic REG_BOND_TOLERANCE = 1'b0;

  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic issue;    // start one comparison
    logic flush;    // emit the held bond as the last one
  } cmd_t;

  typedef struct packed {
    logic job;         // latched atom needs a scan
    logic last_issue;  // current comparison index is the final one
    logic pipe_empty;  // no comparison in flight
    logic adv;         // pipeline may advance
    logic flush_done;  // held bond gone (or none held)
  } status_t;

endpackage

### sv/bpd_controller.sv
// ---------------------------------------------------------------------------
// bpd_controller
// Sequencer: accepts an atom, walks the comparison pipeline over earlier
// atoms, drains it and releases the final bond; no scan: back to idle.
// ---------------------------------------------------------------------------
`include "bond_pair_detector_defines.svh"

module bpd_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bpd_pkg::status_t st,
  output bpd_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    IDLE   = 5'b00001,
    START  = 5'b00010,
    SCAN   = 5'b00100,
    DRAIN  = 5'b01000,
    FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_next = START;
      end
      START: begin
        state_next = st.job ? SCAN : IDLE;
      end
      SCAN: begin
        cmd.issue = st.adv;
        if (st.adv && st.last_issue) state_next = DRAIN;
      end
      DRAIN: begin
        if (st.pipe_empty) state_next = FINISH;
      end
      FINISH: begin
        cmd.flush = 1'b1;
        if (st.flush_done) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  `BPD_ASSERT_NEXT(a_accept_starts, cmd.accept, state == START, "accept did not enter START")
  `BPD_ASSERT_SAME(a_drain_from_scan, state == DRAIN,
                   $past(state) == SCAN || $past(state) == DRAIN, "DRAIN entered out of order")

endmodule

### sv/bpd_datapath.sv
// ---------------------------------------------------------------------------
// bpd_datapath
// Atom store, read/clamp/square compare pipeline, one-bond lookahead for
// the last-bond mark, and the result register.
// ---------------------------------------------------------------------------
`include "bond_pair_detector_defines.svh"

module bpd_datapath #(
  parameter int MAX_ATOMS  = 64,
  parameter int COORD_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bpd_pkg::cmd_t                    cmd,
  output bpd_pkg::status_t                 st,
  input  logic [bpd_pkg::TOL_W-1:0]        bond_tolerance,
  input  logic                             new_molecule,
  input  logic signed [COORD_BITS-1:0]     x_coord,
  input  logic signed [COORD_BITS-1:0]     y_coord,
  input  logic signed [COORD_BITS-1:0]     z_coord,
  input  logic [bpd_pkg::RAD_W-1:0]        covalent_radius,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bpd_pkg::IDX_W-1:0]        earlier_atom,
  output logic [bpd_pkg::IDX_W-1:0]        this_atom,
  output logic                             last_bond
);

  localparam int IDX_BITS = $clog2(MAX_ATOMS);
  localparam int CNT_BITS = $clog2(MAX_ATOMS + 1);
  localparam int WORD_W   = 3 * COORD_BITS + bpd_pkg::RAD_W;
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int CMP_W    = (DIFF_W > bpd_pkg::REACH_W) ? DIFF_W : bpd_pkg::REACH_W;
  localparam int REACH_W  = bpd_pkg::REACH_W;
  localparam int SQ_W     = bpd_pkg::SQ_W;
  localparam int SUM_W    = bpd_pkg::SUM_W;

  // atom store: {radius, z, y, x}
  logic [WORD_W-1:0] mem [MAX_ATOMS];
  logic [WORD_W-1:0] rdata;

  logic [CNT_BITS-1:0] atom_count;
  logic [IDX_BITS-1:0] me, k;
  logic                job;
  logic signed [COORD_BITS-1:0] ax, ay, az;
  logic [bpd_pkg::RAD_W-1:0]    ar;

  logic [CNT_BITS-1:0] cnt_eff;
  logic                room;
  logic                adv;

  assign cnt_eff = new_molecule ? '0 : atom_count;
  assign room    = cnt_eff < CNT_BITS'(MAX_ATOMS);
  assign adv     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept && room) begin
      mem[IDX_BITS'(cnt_eff)] <= {covalent_radius, z_coord, y_coord, x_coord};
    end
    if (cmd.issue) begin
      rdata <= mem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      atom_count <= '0;
      job        <= 1'b0;
    end else if (cmd.accept) begin
      if (room) begin
        atom_count <= cnt_eff + CNT_BITS'(1);
        job        <= (covalent_radius != '0) && (cnt_eff != '0);
      end else begin
        atom_count <= cnt_eff;
        job        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      me <= IDX_BITS'(cnt_eff);
      k  <= '0;
      ax <= x_coord;
      ay <= y_coord;
      az <= z_coord;
      ar <= covalent_radius;
    end else if (cmd.issue) begin
      k <= k + IDX_BITS'(1);
    end
  end

  // stage 1: stored atom read out
  logic                s1_valid;
  logic [IDX_BITS-1:0] s1_idx;

  logic signed [COORD_BITS-1:0] bx, by, bz;
  logic [bpd_pkg::RAD_W-1:0]    br;
  logic signed [DIFF_W-1:0]     dxs, dys, dzs;
  logic [DIFF_W-1:0]            adx, ady, adz;
  logic [REACH_W-1:0]           reach;
  logic                         near;

  always_comb begin
    bx  = rdata[COORD_BITS-1:0];
    by  = rdata[2*COORD_BITS-1:COORD_BITS];
    bz  = rdata[3*COORD_BITS-1:2*COORD_BITS];
    br  = rdata[WORD_W-1:3*COORD_BITS];
    dxs = DIFF_W'(bx) - DIFF_W'(ax);
    dys = DIFF_W'(by) - DIFF_W'(ay);
    dzs = DIFF_W'(bz) - DIFF_W'(az);
    adx = dxs[DIFF_W-1] ? DIFF_W'(-dxs) : DIFF_W'(dxs);
    ady = dys[DIFF_W-1] ? DIFF_W'(-dys) : DIFF_W'(dys);
    adz = dzs[DIFF_W-1] ? DIFF_W'(-dzs) : DIFF_W'(dzs);
    reach = REACH_W'(br) + REACH_W'(ar) + REACH_W'(bond_tolerance);
    near  = (CMP_W'(adx) <= CMP_W'(reach)) && (CMP_W'(ady) <= CMP_W'(reach))
         && (CMP_W'(adz) <= CMP_W'(reach));
  end

  // stage 2: clamped distances; stage 3: squares
  logic                s2_valid, s2_ok, s3_valid, s3_ok;
  logic [IDX_BITS-1:0] s2_idx, s3_idx;
  logic [REACH_W-1:0]  s2_dx, s2_dy, s2_dz, s2_reach;
  logic [SQ_W-1:0]     s3_sqx, s3_sqy, s3_sqz, s3_reach2;
  logic                hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx    <= k;
      s2_idx    <= s1_idx;
      s2_ok     <= s1_valid && (br != '0) && near;
      s2_dx     <= REACH_W'(adx);
      s2_dy     <= REACH_W'(ady);
      s2_dz     <= REACH_W'(adz);
      s2_reach  <= reach;
      s3_idx    <= s2_idx;
      s3_ok     <= s2_ok;
      s3_sqx    <= SQ_W'(s2_dx) * SQ_W'(s2_dx);
      s3_sqy    <= SQ_W'(s2_dy) * SQ_W'(s2_dy);
      s3_sqz    <= SQ_W'(s2_dz) * SQ_W'(s2_dz);
      s3_reach2 <= SQ_W'(s2_reach) * SQ_W'(s2_reach);
    end
  end

  assign hit = s3_valid && s3_ok &&
               (SUM_W'(s3_sqx) + SUM_W'(s3_sqy) + SUM_W'(s3_sqz) <= SUM_W'(s3_reach2));

  // one bond held back so the final one can carry the last mark
  logic                pend_valid;
  logic [IDX_BITS-1:0] pend_idx;
  logic                push_mid, push_last;

  assign push_mid  = adv && hit && pend_valid;
  assign push_last = cmd.flush && pend_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (adv && hit) begin
      pend_valid <= 1'b1;
    end else if (push_last) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hit) pend_idx <= s3_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_mid || push_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_last) begin
      earlier_atom <= bpd_pkg::IDX_W'(pend_idx);
      this_atom    <= bpd_pkg::IDX_W'(me);
      last_bond    <= push_last;
    end
  end

  always_comb begin
    st.job        = job;
    st.last_issue = (k == me - IDX_BITS'(1));
    st.pipe_empty = !(s1_valid || s2_valid || s3_valid);
    st.adv        = adv;
    st.flush_done = !pend_valid || adv;
  end

  `BPD_ASSERT_NEXT(a_stall_holds_pipe, !adv,
                   $stable({s1_valid, s2_valid, s3_valid}), "pipeline moved during stall")
  `BPD_ASSERT_NEXT(a_hit_is_held, adv && hit, pend_valid, "bond lost from lookahead")
  `BPD_ASSERT_SAME(a_idx_below_me, s1_valid, s1_idx < me, "compared atom not below new index")

endmodule

### sv/bond_pair_detector.sv
// ---------------------------------------------------------------------------
// bond_pair_detector
// Covalent-radius bond finder: one atom in, one beat out per bond found.
// ---------------------------------------------------------------------------
// Input stream s_*: one beat per atom, s_tuser = new_molecule (restart
// numbering at zero). Output stream m_*: one beat per bond, earlier index
// first, m_tlast on the final bond of an atom; an atom with no bond gives
// no beat. Atoms past MAX_ATOMS in a molecule are dropped.
// Sequence: after an accept the block goes through start, a read of each
// earlier atom, the three compare stages, an empty check and the final
// release before it takes the next atom; an atom that needs no scan goes
// from start straight back to idle.
// The rate is set by the single read port of the atom store: one stored
// atom is compared per cycle while the output does not stall the pipeline.
// A bond goes through the compare stages into the lookahead register; it is
// held until the next bond or the end of the scan so m_tlast is known.
// m_tready low while a beat is held freezes the compare pipeline; the output
// register holds its beat and nothing is lost. Reset clears the atom count,
// the pipeline, the output and bond_tolerance; the store needs no clearing.
// The user writes bond_tolerance (APB, address 0) only while idle; unchecked.
// ---------------------------------------------------------------------------
module bond_pair_detector #(
  parameter int MAX_ATOMS  = 64,
  parameter int COORD_BITS = 20,
  localparam int IN_BITS   = 3 * COORD_BITS + bpd_pkg::RAD_W,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 2 * bpd_pkg::IDX_W,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // fields from bit 0: x_coord, y_coord, z_coord, covalent_radius
  input  logic [IN_W-1:0]   s_tdata,
  // fields from bit 0: new_molecule
  input  logic              s_tuser,
  input  logic              s_tvalid,
  output logic              s_tready,
  // fields from bit 0: earlier_atom, this_atom
  output logic [OUT_W-1:0]  m_tdata,
  output logic              m_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [bpd_pkg::TOL_W-1:0] bond_tolerance;
  bpd_pkg::cmd_t             cmd;
  bpd_pkg::status_t          st;
  logic [bpd_pkg::IDX_W-1:0] earlier_atom, this_atom;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bond_tolerance <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == bpd_pkg::REG_BOND_TOLERANCE) begin
      bond_tolerance <= pwdata[bpd_pkg::TOL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bpd_pkg::REG_BOND_TOLERANCE) begin
      prdata = 32'(bond_tolerance);
    end
  end

  bpd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  bpd_datapath #(
    .MAX_ATOMS  (MAX_ATOMS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .bond_tolerance  (bond_tolerance),
    .new_molecule    (s_tuser),
    .x_coord         (s_tdata[COORD_BITS-1:0]),
    .y_coord         (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .z_coord         (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .covalent_radius (s_tdata[IN_BITS-1:3*COORD_BITS]),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .earlier_atom    (earlier_atom),
    .this_atom       (this_atom),
    .last_bond       (m_tlast)
  );

  assign m_tdata = OUT_W'({this_atom, earlier_atom});

endmodule

### tb/sv/bond_pair_detector_tb.sv
// ----------------------------------------------------------------------------
// bond_pair_detector_tb
// Self-checking bench for the covalent-radius bond finder. Atoms go in as
// stream beats with bursty pacing; bond beats coming out are matched, in
// order, against a model of the molecule store kept in the bench. A short
// directed table covers the extremes and corner cases, then random molecule
// phases run at several tolerance settings, with a receiver hold-off that
// backs the block up and a full-capacity molecule.
// ----------------------------------------------------------------------------
module bond_pair_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 7;
  localparam int MAX_ATOMS    = 64;
  localparam int IN_W         = 72;
  localparam int OUT_W        = 16;
  localparam int DRAIN_CYCLES = MAX_ATOMS + 16;
  localparam int HOLD_CYCLES  = 500;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic                new_molecule;
    logic signed [19:0]  x;
    logic signed [19:0]  y;
    logic signed [19:0]  z;
    logic [11:0]         radius;
    int                  typed_bonds;    // -1: use the model, else 0 or 1
    logic [5:0]          typed_earlier;
    logic [5:0]          typed_this;
  } atom_row_t;

  typedef struct {
    logic [5:0] earlier_atom;
    logic [5:0] this_atom;
    logic       last_bond;
  } bond_t;

  logic              clk = 1'b0;
  logic              rst;
  logic [IN_W-1:0]   s_tdata;     // from bit 0: x_coord, y_coord, z_coord, covalent_radius
  logic              s_tuser;     // from bit 0: new_molecule
  logic              s_tvalid;
  logic              s_tready;
  logic [OUT_W-1:0]  m_tdata;     // from bit 0: earlier_atom, this_atom
  logic              m_tlast;
  logic              m_tvalid;
  logic              m_tready;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // bench copy of the block state
  int                 mol_count;
  logic signed [19:0] atom_x [MAX_ATOMS];
  logic signed [19:0] atom_y [MAX_ATOMS];
  logic signed [19:0] atom_z [MAX_ATOMS];
  logic [11:0]        atom_r [MAX_ATOMS];
  logic [11:0]        tolerance;

  bond_t     fresh_bonds[$];
  bond_t     bonds_due[$];
  atom_row_t dir_rows[$];

  int  bad_beats   = 0;
  int  cycle_count = 0;
  int  burst_left  = 0;
  bit  pace_gaps   = 1'b1;
  int  hold_token  = 0;

  bond_pair_detector u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void note_mismatch(input string msg);
    if (bad_beats < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    bad_beats++;
  endfunction

  function automatic longint axis_gap(input logic signed [19:0] a, input logic signed [19:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  // bonds caused by one atom, in ascending earlier index, into fresh_bonds
  function automatic void predict_bonds(input logic nm, input logic signed [19:0] x,
                                        input logic signed [19:0] y,
                                        input logic signed [19:0] z,
                                        input logic [11:0] r);
    longint reach, dx, dy, dz;
    bond_t  b;
    fresh_bonds.delete();
    if (nm) mol_count = 0;
    if (mol_count >= MAX_ATOMS) return;
    if (r != 0) begin
      for (int k = 0; k < mol_count; k++) begin
        if (atom_r[k] == 0) continue;
        reach = longint'(atom_r[k]) + longint'(r) + longint'(tolerance);
        dx = axis_gap(atom_x[k], x);
        dy = axis_gap(atom_y[k], y);
        dz = axis_gap(atom_z[k], z);
        // per-axis reject first keeps the squares small
        if (dx > reach || dy > reach || dz > reach) continue;
        if (dx * dx + dy * dy + dz * dz <= reach * reach) begin
          b.earlier_atom = 6'(k);
          b.this_atom    = 6'(mol_count);
          b.last_bond    = 1'b0;
          fresh_bonds    = {fresh_bonds, b};
        end
      end
    end
    if (fresh_bonds.size() > 0) fresh_bonds[fresh_bonds.size() - 1].last_bond = 1'b1;
    atom_x[mol_count] = x;
    atom_y[mol_count] = y;
    atom_z[mol_count] = z;
    atom_r[mol_count] = r;
    mol_count++;
  endfunction

  function automatic atom_row_t mk_row(input int nm, input int x, input int y, input int z,
                                       input int r, input int nb, input int e, input int t);
    atom_row_t row;
    row.new_molecule  = nm[0];
    row.x             = x[19:0];
    row.y             = y[19:0];
    row.z             = z[19:0];
    row.radius        = r[11:0];
    row.typed_bonds   = nb;
    row.typed_earlier = e[5:0];
    row.typed_this    = t[5:0];
    return row;
  endfunction

  function automatic void add_row(input atom_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 11);
    gap = 0;
    if (pace_gaps && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_atom(input atom_row_t row);
    bond_t b;
    pace_sender();
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= row.new_molecule;
    s_tdata  <= {row.radius, row.z, row.y, row.x};
    do @(posedge clk); while (!s_tready);
    predict_bonds(row.new_molecule, row.x, row.y, row.z, row.radius);
    if (row.typed_bonds < 0) begin
      bonds_due = {bonds_due, fresh_bonds};
    end else if (row.typed_bonds == 1) begin
      b.earlier_atom = row.typed_earlier;
      b.this_atom    = row.typed_this;
      b.last_bond    = 1'b1;
      bonds_due      = {bonds_due, b};
    end
  endtask

  // stop offering, let every bond drain, then give a scan with no bond time to finish
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (bonds_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write then read back; the read setup follows the write access directly
  task automatic write_tolerance(input logic [11:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {bpd_pkg::REG_BOND_TOLERANCE, 2'b00};
    pwdata  <= {20'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tolerance = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[11:0] !== value)
      note_mismatch($sformatf("bond_tolerance readback exp=%03h got=%03h", value, prdata[11:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input int quota, input int first_size);
    int                 sent, size, spread, offset;
    logic signed [19:0] cx, cy, cz;
    atom_row_t          row;
    sent = 0;
    while (sent < quota) begin
      if (sent == 0 && first_size > 0) size = first_size;
      else if ($urandom_range(0, 7) == 0) size = $urandom_range(17, 40);
      else size = $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0: spread = 'h80;
        1: spread = 'h300;
        2: spread = 'h1000;
        default: spread = 'h8000;
      endcase
      if (first_size > 0 && sent == 0) spread = 'h100;
      cx = 20'($urandom_range(0, 20'hFFFFF));
      cy = 20'($urandom_range(0, 20'hFFFFF));
      cz = 20'($urandom_range(0, 20'hFFFFF));
      for (int i = 0; i < size && sent < quota; i++) begin
        row.typed_bonds   = -1;
        row.typed_earlier = '0;
        row.typed_this    = '0;
        if ($urandom_range(0, 9) == 0) begin
          // stray beat: anything at all, possibly restarting mid-molecule
          row.new_molecule = 1'($urandom_range(0, 1));
          row.x      = 20'($urandom);
          row.y      = 20'($urandom);
          row.z      = 20'($urandom);
          row.radius = 12'($urandom);
        end else begin
          row.new_molecule = (i == 0);
          offset = int'($urandom_range(0, 2 * spread)) - spread;
          row.x  = 20'(cx + offset);
          offset = int'($urandom_range(0, 2 * spread)) - spread;
          row.y  = 20'(cy + offset);
          offset = int'($urandom_range(0, 2 * spread)) - spread;
          row.z  = 20'(cz + offset);
          case ($urandom_range(0, 9))
            0: row.radius = '0;
            1: row.radius = 12'($urandom);
            default: row.radius = 12'($urandom_range('h40, 'h500));
          endcase
        end
        send_atom(row);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin : bond_monitor
    bond_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (bonds_due.size() == 0) begin
        note_mismatch($sformatf("unexpected bond earlier=%0d this=%0d last=%0b",
                                m_tdata[5:0], m_tdata[11:6], m_tlast));
      end else begin
        want = bonds_due.pop_front();
        if (m_tdata[5:0] !== want.earlier_atom || m_tdata[11:6] !== want.this_atom ||
            m_tlast !== want.last_bond)
          note_mismatch($sformatf("bond exp (%0d,%0d,last=%0b) got (%0d,%0d,last=%0b)",
                                  want.earlier_atom, want.this_atom, want.last_bond,
                                  m_tdata[5:0], m_tdata[11:6], m_tlast));
      end
    end
  end

  // receiver: changing stall pattern, plus a long hold-off on request
  initial begin : rx_pattern
    int   mode, left, run;
    logic rdy;
    int   hold_seen;
    mode      = 0;
    left      = 0;
    run       = 0;
    rdy       = 1'b1;
    hold_seen = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(32, 200);
        end
        left--;
        case (mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) != 0);
          default: begin
            if (run == 0) begin
              rdy = ~rdy;
              run = $urandom_range(1, 8);
            end
            run--;
          end
        endcase
        m_tready <= rdy;
      end
    end
  end

  initial begin : main
    rst       = 1'b1;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    s_tvalid  = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    mol_count = 0;
    tolerance = '0;

    //             nm  x            y           z        r      n  e  t
    add_row(mk_row(1, 0,          0,        0,       'h100, 0, 0, 0)); // first atom
    add_row(mk_row(0, 'h200,      0,        0,       'h100, 1, 0, 1)); // exactly at reach
    add_row(mk_row(0, 0,          0,        0,       0,     0, 0, 0)); // zero radius
    add_row(mk_row(0, 524287,     524287,   524287,  'hFFF, 0, 0, 0)); // far corner
    add_row(mk_row(0, -524288,    -524288,  -524288, 'hFFF, 0, 0, 0)); // other corner
    add_row(mk_row(0, -520192,    -524288,  -524288, 'hFFF, 1, 4, 5));
    add_row(mk_row(0, 'h100,      0,        0,       'h100, -1, 0, 0));
    add_row(mk_row(1, 0,          0,        0,       1,     0, 0, 0));
    add_row(mk_row(0, 3,          0,        0,       1,     0, 0, 0)); // one past reach
    add_row(mk_row(0, 1,          2,        0,       1,     0, 0, 0)); // axes ok, sum not
    add_row(mk_row(0, 2,          0,        0,       1,     -1, 0, 0));
    add_row(mk_row(1, 524287,     -524288,  0,       'hFFF, 0, 0, 0));
    add_row(mk_row(0, 516097,     -524288,  0,       'hFFF, 1, 0, 1));
    add_row(mk_row(0, 'h7F000,    -'h7F000, 'h1000,  'hABC, -1, 0, 0));
    add_row(mk_row(1, 0,          0,        0,       0,     0, 0, 0)); // zero-radius first
    add_row(mk_row(0, 0,          0,        0,       'hFFF, 0, 0, 0)); // partner has none
    add_row(mk_row(0, 'h10,       'h10,     'h10,    'h800, 1, 1, 2));
    add_row(mk_row(0, -'h100,     'h55555,  -'h2AAAA, 'h555, -1, 0, 0));
    add_row(mk_row(1, 'h2AAAA,    -'h55556, 'h55555, 'hAAA, 0, 0, 0));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_tolerance(12'h000);
    foreach (dir_rows[i]) send_atom(dir_rows[i]);
    settle();

    // max tolerance, receiver backs off while the sender keeps pushing,
    // and a molecule that runs past capacity
    write_tolerance(12'hFFF);
    hold_token++;
    run_phase(100, MAX_ATOMS + 3);
    settle();

    pace_gaps = 1'b0;
    write_tolerance(12'($urandom));
    run_phase(80, 0);
    settle();

    pace_gaps = 1'b1;
    write_tolerance(12'h001);
    run_phase(80, 0);
    settle();

    write_tolerance(12'($urandom));
    run_phase(80, MAX_ATOMS + 1);
    settle();

    if (bonds_due.size() != 0)
      note_mismatch($sformatf("%0d bonds never arrived", bonds_due.size()));
    if (bad_beats == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
